// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/i2dtxt_pkg.sv =====
`timescale 1ns / 1ps

package i2dtxt_pkg;

    localparam int FIELD_MAX = 32;
    localparam int DIGITS    = 20;
    localparam int MAX_CHARS = DIGITS + 1;
    localparam int CNT_W     = $clog2(((FIELD_MAX > MAX_CHARS) ? FIELD_MAX : MAX_CHARS) + 1);
    localparam int DIG_W     = $clog2(DIGITS);
    localparam int FW_W      = 6;
    localparam int POS_W     = 16;
    localparam int LEN_W     = 16;
    localparam int VAL_W     = 64;
    localparam int TYPE_W    = 4;
    localparam int STEP_BITS = 4;
    localparam int GRP_W     = $clog2(VAL_W / STEP_BITS + 1);

    // data type codes; bit 3 clear means integer, bit 2 signed, bits 1:0 size
    localparam logic [TYPE_W-1:0] DT_TEXT = 4'd8;
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_QUAD = 2'd3;

    // configuration register indexes
    localparam logic REG_DEST_DYNAMIC = 1'b0;
    localparam logic REG_FIELD_WIDTH  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        STAT_NORMAL  = 2'd0,
        STAT_TRUNC   = 2'd1,
        STAT_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SETUP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic setup;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_int;
        logic conv_last;
        logic emit_none;
        logic emit_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/i2dtxt_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2dtxt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  i2dtxt_pkg::t_dp_status i_st,
    output i2dtxt_pkg::t_dp_cmd    o_cmd
);
    import i2dtxt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_st.in_is_int ? S_CONV : S_EMIT;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_st.conv_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                priority if (i_st.emit_none) begin
                    n_state = S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    `ASSERT_IMPLIES(a_emit_free, o_cmd.emit, i_st.out_free, "emit while output register busy")

endmodule

// ===== hw/rtl/i2dtxt_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2dtxt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [i2dtxt_pkg::FW_W-1:0]     i_cfg_wdata,
    input  logic [i2dtxt_pkg::TYPE_W-1:0]   i_type,
    input  logic [i2dtxt_pkg::VAL_W-1:0]    i_value,
    input  logic                            i_char_present,
    input  logic                            i_text_last,
    input  i2dtxt_pkg::t_dp_cmd             i_cmd,
    output i2dtxt_pkg::t_dp_status          o_st,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [7:0]                      o_char,
    output logic                            o_char_valid,
    output logic                            o_last,
    output i2dtxt_pkg::t_status             o_status,
    output logic [i2dtxt_pkg::LEN_W-1:0]    o_len
);
    import i2dtxt_pkg::*;

    // configuration and control state
    logic              r_dyn;
    logic [FW_W-1:0]   r_fw;
    logic [POS_W-1:0]  r_text_pos;
    logic [GRP_W-1:0]  r_grp;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_idx;
    logic              r_out_valid;

    // payload
    logic [VAL_W-1:0]  r_shift;
    logic [3:0]        r_bcd [DIGITS];
    logic              r_neg;
    logic [7:0]        r_tbyte;
    logic              r_is_text;
    logic [CNT_W-1:0]  r_head;
    logic              r_empty;
    logic              r_fin;
    t_status           r_status;
    logic [LEN_W-1:0]  r_rlen;
    logic [7:0]        r_out_char;
    logic              r_out_cv;
    logic              r_out_last;
    t_status           r_out_status;
    logic [LEN_W-1:0]  r_out_len;

    logic [CNT_W-1:0]  field;
    logic [VAL_W-1:0]  vm;
    logic [VAL_W-1:0]  mask;
    logic [VAL_W-1:0]  mag;
    logic [VAL_W-1:0]  aligned;
    logic [GRP_W-1:0]  grp;
    logic              sign_bit;
    logic              neg;

    logic              has_char;
    logic [POS_W-1:0]  pos_next;
    logic [CNT_W-1:0]  t_stored;
    logic [CNT_W-1:0]  t_total;
    logic              t_trunc;

    logic [CNT_W-1:0]  nd;
    logic [CNT_W-1:0]  int_len;

    logic [3:0]        bcd_w [DIGITS];
    logic [VAL_W-1:0]  sh_w;

    logic [CNT_W-1:0]  k;
    logic [7:0]        ch;
    logic              is_last;

    assign field = (r_fw > FW_W'(FIELD_MAX)) ? CNT_W'(FIELD_MAX) : CNT_W'(r_fw);

    // operand capture: mask to type width, take magnitude, left-align
    always_comb begin
        unique case (i_type[1:0])
            SZ_BYTE: begin
                mask     = VAL_W'(8'hFF);
                sign_bit = i_value[7];
                grp      = GRP_W'(8 / STEP_BITS);
            end
            SZ_WORD: begin
                mask     = VAL_W'(16'hFFFF);
                sign_bit = i_value[15];
                grp      = GRP_W'(16 / STEP_BITS);
            end
            SZ_LONG: begin
                mask     = VAL_W'(32'hFFFF_FFFF);
                sign_bit = i_value[31];
                grp      = GRP_W'(32 / STEP_BITS);
            end
            SZ_QUAD: begin
                mask     = '1;
                sign_bit = i_value[VAL_W-1];
                grp      = GRP_W'(VAL_W / STEP_BITS);
            end
        endcase
        vm  = i_value & mask;
        neg = i_type[2] & sign_bit;
        mag = neg ? ((~vm + VAL_W'(1)) & mask) : vm;
        unique case (i_type[1:0])
            SZ_BYTE: aligned = mag << (VAL_W - 8);
            SZ_WORD: aligned = mag << (VAL_W - 16);
            SZ_LONG: aligned = mag << (VAL_W - 32);
            SZ_QUAD: aligned = mag;
        endcase
    end

    // text item bookkeeping
    always_comb begin
        has_char = i_char_present && (r_dyn || (r_text_pos < POS_W'(field)));
        pos_next = (i_char_present && (r_text_pos != '1)) ? r_text_pos + POS_W'(1)
                                                          : r_text_pos;
        t_stored = (pos_next < POS_W'(field)) ? pos_next[CNT_W-1:0] : field;
        t_trunc  = pos_next > POS_W'(field);
        t_total  = r_dyn ? CNT_W'(has_char) : CNT_W'(has_char) + field - t_stored;
    end

    // shift-and-add-3, STEP_BITS source bits per cycle
    always_comb begin
        bcd_w = r_bcd;
        sh_w  = r_shift;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (bcd_w[d] >= 4'd5) begin
                    bcd_w[d] = bcd_w[d] + 4'd3;
                end
            end
            for (int d = DIGITS - 1; d > 0; d--) begin
                bcd_w[d] = {bcd_w[d][2:0], bcd_w[d-1][3]};
            end
            bcd_w[0] = {bcd_w[0][2:0], sh_w[VAL_W-1]};
            sh_w     = sh_w << 1;
        end
    end

    // significant digit count, at least one
    always_comb begin
        nd = CNT_W'(1);
        for (int d = 1; d < DIGITS; d++) begin
            if (r_bcd[d] != 4'd0) begin
                nd = CNT_W'(d + 1);
            end
        end
        int_len = nd + CNT_W'(r_neg);
    end

    // character for the current result position
    always_comb begin
        k       = r_head - CNT_W'(1) - r_idx;
        is_last = r_fin && (r_idx == r_cnt - CNT_W'(1));
        priority if (r_empty) begin
            ch = 8'h00;
        end else if (r_idx >= r_head) begin
            ch = CH_SPACE;
        end else if (r_is_text) begin
            ch = r_tbyte;
        end else if (r_neg && (r_idx == '0)) begin
            ch = CH_MINUS;
        end else begin
            ch = CH_ZERO + {4'b0000, r_bcd[k[DIG_W-1:0]]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn       <= 1'b0;
            r_fw        <= FW_W'(16);
            r_text_pos  <= '0;
            r_grp       <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DEST_DYNAMIC: r_dyn <= i_cfg_wdata[0];
                    REG_FIELD_WIDTH:  r_fw  <= i_cfg_wdata;
                endcase
            end
            if (i_cmd.load) begin
                r_idx <= '0;
                priority if (!i_type[3]) begin
                    r_text_pos <= '0;
                    r_grp      <= grp;
                    r_cnt      <= '0;
                end else if (i_type == DT_TEXT) begin
                    if (i_text_last) begin
                        r_text_pos <= '0;
                        r_cnt      <= (t_total == '0) ? CNT_W'(1) : t_total;
                    end else begin
                        r_text_pos <= pos_next;
                        r_cnt      <= CNT_W'(has_char);
                    end
                end else begin
                    // unsupported type: drop text in progress, one empty result
                    r_text_pos <= '0;
                    r_cnt      <= CNT_W'(1);
                end
            end
            if (i_cmd.step) begin
                r_grp <= r_grp - GRP_W'(1);
            end
            if (i_cmd.setup) begin
                r_cnt <= r_dyn ? int_len : ((field == '0) ? CNT_W'(1) : field);
            end
            if (i_cmd.emit) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tbyte   <= i_value[7:0];
            r_is_text <= (i_type == DT_TEXT);
            priority if (!i_type[3]) begin
                r_shift <= aligned;
                r_neg   <= neg;
                for (int d = 0; d < DIGITS; d++) begin
                    r_bcd[d] <= 4'd0;
                end
            end else if (i_type == DT_TEXT) begin
                r_neg   <= 1'b0;
                r_head  <= CNT_W'(has_char);
                r_fin   <= i_text_last;
                r_empty <= i_text_last && (t_total == '0);
                if (r_dyn) begin
                    r_status <= STAT_NORMAL;
                    r_rlen   <= pos_next;
                end else begin
                    r_status <= t_trunc ? STAT_TRUNC : STAT_NORMAL;
                    r_rlen   <= LEN_W'(t_stored);
                end
            end else begin
                r_neg    <= 1'b0;
                r_head   <= '0;
                r_fin    <= 1'b1;
                r_empty  <= 1'b1;
                r_status <= STAT_INVALID;
                r_rlen   <= '0;
            end
        end
        if (i_cmd.step) begin
            r_bcd   <= bcd_w;
            r_shift <= sh_w;
        end
        if (i_cmd.setup) begin
            r_head  <= int_len;
            r_fin   <= 1'b1;
            r_empty <= !r_dyn && (field == '0);
            if (r_dyn) begin
                r_status <= STAT_NORMAL;
                r_rlen   <= LEN_W'(int_len);
            end else begin
                r_status <= (int_len > field) ? STAT_TRUNC : STAT_NORMAL;
                r_rlen   <= LEN_W'((int_len < field) ? int_len : field);
            end
        end
        if (i_cmd.emit) begin
            r_out_char   <= ch;
            r_out_cv     <= !r_empty;
            r_out_last   <= is_last;
            r_out_status <= is_last ? r_status : STAT_NORMAL;
            r_out_len    <= is_last ? r_rlen : '0;
        end
    end

    always_comb begin
        o_st.in_is_int = !i_type[3];
        o_st.conv_last = (r_grp == GRP_W'(1));
        o_st.emit_none = (r_cnt == '0);
        o_st.emit_last = (r_idx == r_cnt - CNT_W'(1));
        o_st.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_char       = r_out_char;
    assign o_char_valid = r_out_cv;
    assign o_last       = r_out_last;
    assign o_status     = r_out_status;
    assign o_len        = r_out_len;

    `ASSERT_HOLDS(a_idx_range, r_idx <= r_cnt, "result index ran past result count")
    `ASSERT_IMPLIES(a_empty_last, r_out_valid && !r_out_cv, r_out_last, "empty result not last")
    `ASSERT_IMPLIES(a_tail_clean, r_out_valid && !r_out_last, (r_out_status == STAT_NORMAL) && (r_out_len == '0), "status on non-final beat")

endmodule

// ===== hw/rtl/integer_to_decimal_field_text.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tdata value, tuser type+char_present, tlast
// m_axis   out  m_axis_tvalid/tready       tdata char/status/length, tuser char_valid
// cfg      in   i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// Text item: taken in S_IDLE, then its beats go out in S_EMIT, or it returns to S_IDLE when
// it gives none. Integer item (W = 8, 16, 32 or 64 bits): taken in S_IDLE, converted in
// S_CONV by the 4-bit-per-cycle shift-and-add-3 unit, set up in S_SETUP, then emitted in
// S_EMIT. Beats leave through the single output register, one whenever it is free.
// Reset is synchronous: fixed mode, field width 16, no text open. A low m_axis_tready
// while m_axis_tvalid is high holds the output register and the beat counter.

module integer_to_decimal_field_text (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // value[63:0]
    input  logic [4:0]                        s_axis_tuser,  // data_type[3:0], char_present
    input  logic                              s_axis_tlast,  // text_last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // out_char, status, result_length
    output logic [0:0]                        m_axis_tuser,  // char_valid
    output logic                              m_axis_tlast,  // is_last
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [i2dtxt_pkg::FW_W-1:0]       i_cfg_wdata
);
    import i2dtxt_pkg::*;

    t_dp_cmd          cmd;
    t_dp_status       st;
    logic [7:0]       out_char;
    logic             out_cv;
    t_status          out_status;
    logic [LEN_W-1:0] out_len;

    i2dtxt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    i2dtxt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_type         (s_axis_tuser[3:0]),
        .i_value        (s_axis_tdata),
        .i_char_present (s_axis_tuser[4]),
        .i_text_last    (s_axis_tlast),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_char         (out_char),
        .o_char_valid   (out_cv),
        .o_last         (m_axis_tlast),
        .o_status       (out_status),
        .o_len          (out_len)
    );

    assign m_axis_tdata = {6'b000000, out_len, out_status, out_char};
    assign m_axis_tuser = out_cv;

endmodule
